// File: sv/acc_alu_pkg.sv
package acc_alu_pkg;

  // Fixed widths of the channel fields
  localparam int IO_BITS    = 16;
  localparam int CMD_BITS   = 4;
  localparam int SHAMT_BITS = 6;

  typedef logic [CMD_BITS-1:0] cmd_t;

  // Operation codes
  localparam cmd_t CMD_LOAD  = 4'd0;
  localparam cmd_t CMD_NAND  = 4'd1;
  localparam cmd_t CMD_ADD   = 4'd2;
  localparam cmd_t CMD_SUB   = 4'd3;
  localparam cmd_t CMD_AND   = 4'd4;
  localparam cmd_t CMD_OR    = 4'd5;
  localparam cmd_t CMD_XOR   = 4'd6;
  localparam cmd_t CMD_NOT   = 4'd7;
  localparam cmd_t CMD_NEG   = 4'd8;
  localparam cmd_t CMD_SHR1  = 4'd9;
  localparam cmd_t CMD_SHIFT = 4'd10;
  localparam cmd_t CMD_MUL   = 4'd11;

  // Status flags, packed as N O C Z from msb to lsb
  typedef struct packed {
    logic n;
    logic o;
    logic c;
    logic z;
  } flags_t;

endpackage

// File: sv/acc_alu_if.sv
interface acc_alu_in_if;
  logic                                        valid;
  logic                                        ready;
  acc_alu_pkg::cmd_t                           command;
  logic [acc_alu_pkg::IO_BITS-1:0]             operand;
  logic signed [acc_alu_pkg::SHAMT_BITS-1:0]   shift_amount;

  modport source (output valid, command, operand, shift_amount, input ready);
  modport sink   (input valid, command, operand, shift_amount, output ready);
endinterface

interface acc_alu_out_if;
  logic                            valid;
  logic                            ready;
  logic [acc_alu_pkg::IO_BITS-1:0] accumulator;
  logic                            zero_flag;
  logic                            carry_flag;
  logic                            overflow_flag;
  logic                            negative_flag;

  modport source (output valid, accumulator, zero_flag, carry_flag, overflow_flag,
                  negative_flag, input ready);
  modport sink   (input valid, accumulator, zero_flag, carry_flag, overflow_flag,
                  negative_flag, output ready);
endinterface

// File: sv/acc_alu_exec.sv
module acc_alu_exec #(
  parameter int WORD_BITS = 16
) (
  input  acc_alu_pkg::cmd_t                          cmd,
  input  logic [acc_alu_pkg::IO_BITS-1:0]            operand,
  input  logic signed [acc_alu_pkg::SHAMT_BITS-1:0]  shift_amount,
  input  logic [WORD_BITS-1:0]                       acc,
  input  acc_alu_pkg::flags_t                        flags,
  output logic [WORD_BITS-1:0]                       acc_nxt,
  output acc_alu_pkg::flags_t                        flags_nxt
);

  localparam int EXT_BITS = (WORD_BITS > acc_alu_pkg::IO_BITS) ? WORD_BITS
                                                                : acc_alu_pkg::IO_BITS;

  logic [EXT_BITS-1:0]  opnd_ext;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] neg_b;
  logic [WORD_BITS-1:0] addend;
  logic [WORD_BITS-1:0] sum;
  logic                 add_c;
  logic                 add_o;
  logic [4:0]           lsh_m1;
  logic [4:0]           rsh_m1;
  logic [WORD_BITS-1:0] lsh_part;
  logic [WORD_BITS-1:0] rsh_part;
  logic [WORD_BITS-1:0] prod;
  logic                 c_nxt;
  logic                 o_nxt;
  logic                 hold;
  logic                 z_only;

  // Fit the operand to the word
  assign opnd_ext = EXT_BITS'(operand);
  assign b        = opnd_ext[WORD_BITS-1:0];

  // Adder shared by add and subtract; subtract adds the two's negation
  assign neg_b  = (~b) + WORD_BITS'(1);
  assign addend = (cmd == acc_alu_pkg::CMD_SUB) ? neg_b : b;
  assign {add_c, sum} = {1'b0, acc} + {1'b0, addend};
  assign add_o  = (acc[WORD_BITS-1] == addend[WORD_BITS-1]) &&
                  (sum[WORD_BITS-1] != acc[WORD_BITS-1]);

  // Barrel shift by one less than the amount; the last step yields C, and O for a left shift
  assign lsh_m1   = shift_amount[4:0] - 5'd1;
  assign rsh_m1   = ~shift_amount[4:0];
  assign lsh_part = acc << lsh_m1;
  assign rsh_part = acc >> rsh_m1;

  // Low half of the product
  assign prod = acc * b;

  // Decode the operation
  always_comb begin
    acc_nxt = acc;
    c_nxt   = 1'b0;
    o_nxt   = 1'b0;
    hold    = 1'b0;
    z_only  = 1'b0;
    unique case (cmd) inside
      acc_alu_pkg::CMD_LOAD: acc_nxt = b;
      acc_alu_pkg::CMD_NAND: acc_nxt = ~(acc & b);
      acc_alu_pkg::CMD_ADD, acc_alu_pkg::CMD_SUB: begin
        acc_nxt = sum;
        c_nxt   = add_c;
        o_nxt   = add_o;
      end
      acc_alu_pkg::CMD_AND:  acc_nxt = acc & b;
      acc_alu_pkg::CMD_OR:   acc_nxt = acc | b;
      acc_alu_pkg::CMD_XOR:  acc_nxt = acc ^ b;
      acc_alu_pkg::CMD_NOT:  acc_nxt = ~acc;
      acc_alu_pkg::CMD_NEG:  acc_nxt = (~acc) + WORD_BITS'(1);
      acc_alu_pkg::CMD_SHR1: acc_nxt = acc >> 1;
      acc_alu_pkg::CMD_SHIFT: begin
        if (shift_amount == '0) begin
          z_only = 1'b1;
        end else if (shift_amount[acc_alu_pkg::SHAMT_BITS-1]) begin
          acc_nxt = rsh_part >> 1;
          c_nxt   = rsh_part[0];
        end else begin
          acc_nxt = lsh_part << 1;
          c_nxt   = lsh_part[WORD_BITS-1];
          o_nxt   = lsh_part[WORD_BITS-1] ^ lsh_part[WORD_BITS-2];
        end
      end
      acc_alu_pkg::CMD_MUL:  acc_nxt = prod;
      default:               hold = 1'b1;
    endcase
  end

  // Build the new flags
  always_comb begin
    if (hold) begin
      flags_nxt = flags;
    end else if (z_only) begin
      flags_nxt   = flags;
      flags_nxt.z = (acc == '0);
    end else begin
      flags_nxt.n = acc_nxt[WORD_BITS-1];
      flags_nxt.o = o_nxt;
      flags_nxt.c = c_nxt;
      flags_nxt.z = (acc_nxt == '0);
    end
  end

endmodule

// File: sv/accumulator_alu_with_flags_top.sv
// Channel | Dir | Payload                                          | Handshake
// in_ch   | in  | command[3:0], operand[15:0], shift_amount[5:0]   | valid/ready
// out_ch  | out | accumulator[15:0], zero/carry/overflow/negative  | valid/ready
//
// One request per cycle sustained while results are taken; each request passes
// through the input register and then waits in the result register until it is
// taken. The loop through the combinational ALU and the accumulator register sets
// the rate. Reset (rst_n low, synchronous) clears the accumulator, the flags and
// both valid bits. A stalled result holds the pipe; new requests are still taken
// while the input register is free or moving on.
module accumulator_alu_with_flags_top #(
  parameter int WORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  acc_alu_in_if.sink    in_ch,
  acc_alu_out_if.source out_ch
);

  localparam int EXT_BITS = (WORD_BITS > acc_alu_pkg::IO_BITS) ? WORD_BITS
                                                                : acc_alu_pkg::IO_BITS;

  // Input register
  logic                                       in_v_r;
  acc_alu_pkg::cmd_t                          cmd_r;
  logic [acc_alu_pkg::IO_BITS-1:0]            opnd_r;
  logic signed [acc_alu_pkg::SHAMT_BITS-1:0]  shamt_r;

  // Architectural state
  logic [WORD_BITS-1:0]  acc_r;
  logic [WORD_BITS-1:0]  acc_nxt;
  acc_alu_pkg::flags_t   flags_r;
  acc_alu_pkg::flags_t   flags_nxt;

  // Result register
  logic                            out_v_r;
  logic [acc_alu_pkg::IO_BITS-1:0] out_acc_r;
  acc_alu_pkg::flags_t             out_flags_r;

  logic [EXT_BITS-1:0] acc_ext;
  logic                advance;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r   <= in_ch.command;
      opnd_r  <= in_ch.operand;
      shamt_r <= in_ch.shift_amount;
    end
  end

  acc_alu_exec #(
    .WORD_BITS(WORD_BITS)
  ) u_exec (
    .cmd          (cmd_r),
    .operand      (opnd_r),
    .shift_amount (shamt_r),
    .acc          (acc_r),
    .flags        (flags_r),
    .acc_nxt      (acc_nxt),
    .flags_nxt    (flags_nxt)
  );

  // Advance the accumulator and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      flags_r <= '0;
    end else if (advance) begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Load the result register; drop it once taken
  assign acc_ext = EXT_BITS'(acc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_acc_r   <= acc_ext[acc_alu_pkg::IO_BITS-1:0];
      out_flags_r <= flags_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.accumulator   = out_acc_r;
  assign out_ch.zero_flag     = out_flags_r.z;
  assign out_ch.carry_flag    = out_flags_r.c;
  assign out_ch.overflow_flag = out_flags_r.o;
  assign out_ch.negative_flag = out_flags_r.n;

`ifndef SYNTH
  // N always tracks the accumulator sign bit
  a_sign_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.n == acc_r[WORD_BITS-1])
    else $error("negative flag out of step with accumulator");

  // An item leaving the input register shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("result missing after advance");

  // A held request stays in the input register
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r)
    else $error("request lost while stalled");

  // AND and XOR clear carry and overflow
  a_logic_clears_co: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd_r == acc_alu_pkg::CMD_AND || cmd_r == acc_alu_pkg::CMD_XOR)
    |=> !flags_r.c && !flags_r.o)
    else $error("carry or overflow left set by bitwise operation");
`endif

endmodule
